@@ sv/tbo_pkg.sv @@
`default_nettype none

package tbo_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LO_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LO_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LO_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HI_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HI_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HI_Z = 3'd5;

  // Pipeline depth: three setup stages, four cell stages, one output stage.
  localparam int NUM_STAGES = 8;

  // Load enables of the four register stages inside an axis cell.
  typedef struct packed {
    logic c1;
    logic c2;
    logic c3;
    logic c4;
  } cell_en_t;

endpackage

`default_nettype wire

@@ sv/tbo_axis_cell.sv @@
`default_nettype none

module tbo_axis_cell #(
  parameter int COORD_BITS = 16,
  parameter int AXIS_BITS  = 17
) (
  input  logic                         clk_i,
  input  tbo_pkg::cell_en_t            en_i,
  input  logic signed [AXIS_BITS-1:0]  axis_i   [3],
  input  logic signed [COORD_BITS-1:0] box_lo_i [3],
  input  logic signed [COORD_BITS-1:0] box_hi_i [3],
  input  logic signed [COORD_BITS-1:0] vert_i   [3][3],
  output logic                         sep_o
);
  import tbo_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int LB = AXIS_BITS / 2;
  localparam int HB = AXIS_BITS - LB;
  localparam int PH = HB + W;
  localparam int PL = LB + 1 + W;
  localparam int PW = AXIS_BITS + W;
  localparam int SW = PW + 2;

  logic signed [W-1:0]  opnd [5][3];
  logic signed [HB-1:0] ax_hi [3];
  logic signed [LB:0]   ax_lo [3];
  logic signed [PH-1:0] ph_d [5][3];
  logic signed [PH-1:0] ph_q [5][3];
  logic signed [PL-1:0] pl_d [5][3];
  logic signed [PL-1:0] pl_q [5][3];
  logic signed [PW-1:0] full [5][3];
  logic signed [PW-1:0] bmn_d [3];
  logic signed [PW-1:0] bmn_q [3];
  logic signed [PW-1:0] bmx_d [3];
  logic signed [PW-1:0] bmx_q [3];
  logic signed [PW-1:0] tp_d [3][3];
  logic signed [PW-1:0] tp_q [3][3];
  logic signed [SW-1:0] bsum_mn_d, bsum_mn_q, bsum_mx_d, bsum_mx_q;
  logic signed [SW-1:0] tsum_d [3];
  logic signed [SW-1:0] tsum_q [3];
  logic signed [SW-1:0] tmn, tmx;
  logic                 sep_d, sep_q;

  // First stage: the axis is split into a signed high half and an unsigned
  // low half so that each multiplier stays narrow.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      opnd[0][k] = box_lo_i[k];
      opnd[1][k] = box_hi_i[k];
      for (int j = 0; j < 3; j++) begin
        opnd[2+j][k] = vert_i[j][k];
      end
      ax_hi[k] = axis_i[k][AXIS_BITS-1:LB];
      ax_lo[k] = $signed({1'b0, axis_i[k][LB-1:0]});
      for (int m = 0; m < 5; m++) begin
        ph_d[m][k] = PH'(ax_hi[k]) * PH'(opnd[m][k]);
        pl_d[m][k] = PL'(ax_lo[k]) * PL'(opnd[m][k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.c1) begin
      ph_q <= ph_d;
      pl_q <= pl_d;
    end
  end

  // Second stage: rebuild the full products, then pick the box corner
  // extremes per component.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 5; m++) begin
        full[m][k] = (PW'(ph_q[m][k]) <<< LB) + PW'(pl_q[m][k]);
      end
      bmn_d[k] = (full[0][k] < full[1][k]) ? full[0][k] : full[1][k];
      bmx_d[k] = (full[0][k] < full[1][k]) ? full[1][k] : full[0][k];
      for (int j = 0; j < 3; j++) begin
        tp_d[j][k] = full[2+j][k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.c2) begin
      bmn_q <= bmn_d;
      bmx_q <= bmx_d;
      tp_q  <= tp_d;
    end
  end

  // Third stage: sum the components into projections.
  always_comb begin
    bsum_mn_d = SW'(bmn_q[0]) + SW'(bmn_q[1]) + SW'(bmn_q[2]);
    bsum_mx_d = SW'(bmx_q[0]) + SW'(bmx_q[1]) + SW'(bmx_q[2]);
    for (int j = 0; j < 3; j++) begin
      tsum_d[j] = SW'(tp_q[j][0]) + SW'(tp_q[j][1]) + SW'(tp_q[j][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.c3) begin
      bsum_mn_q <= bsum_mn_d;
      bsum_mx_q <= bsum_mx_d;
      tsum_q    <= tsum_d;
    end
  end

  // Fourth stage: strict interval test, so a zero axis never separates.
  always_comb begin
    tmn = tsum_q[0];
    tmx = tsum_q[0];
    for (int j = 1; j < 3; j++) begin
      if (tsum_q[j] < tmn) tmn = tsum_q[j];
      if (tsum_q[j] > tmx) tmx = tsum_q[j];
    end
    sep_d = (bsum_mx_q < tmn) || (bsum_mn_q > tmx);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.c4) begin
      sep_q <= sep_d;
    end
  end

  assign sep_o = sep_q;

endmodule

`default_nettype wire

@@ sv/triangle_box_overlap_test_core.sv @@
// Triangle versus box overlap test, thirteen separating axes.
// Throughput: one triangle per cycle; the ten axis cells and the setup
// stages are fully pipelined, stalls only where the output is not taken.
// Reset clears all stage valid bits and sets the six box registers to zero.
`default_nettype none

module triangle_box_overlap_test_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [tbo_pkg::CFG_IDX_W-1:0]            cfg_idx_i,
  input  logic [COORD_BITS-1:0]                    cfg_data_i,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up, zero padded
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // overlaps in bit 0, zero padded
  output logic [7:0]                               m_axis_tdata
);
  import tbo_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int EW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int NW = 2 * W + 3;

  logic signed [W-1:0]  box_lo_q [3];
  logic signed [W-1:0]  box_hi_q [3];
  logic signed [W-1:0]  in_v [3][3];
  logic [NUM_STAGES-1:0] vld_q, vld_d, rdy;

  logic signed [W-1:0]  vmn [3];
  logic signed [W-1:0]  vmx [3];
  logic                 sepbox_d;
  logic signed [EW-1:0] eu_d [3];
  logic signed [EW-1:0] ev_d [3];
  logic signed [EW-1:0] edge_d [3][3];

  logic signed [EW-1:0] eu_q [3];
  logic signed [EW-1:0] ev_q [3];
  logic signed [EW-1:0] edge1_q [3][3];
  logic signed [EW-1:0] edge2_q [3][3];
  logic signed [EW-1:0] edge3_q [3][3];
  logic signed [W-1:0]  vert1_q [3][3];
  logic signed [W-1:0]  vert2_q [3][3];
  logic signed [W-1:0]  vert3_q [3][3];
  logic                 sb_q [7];
  logic signed [PW-1:0] np_d [6];
  logic signed [PW-1:0] np_q [6];
  logic signed [NW-1:0] n_d [3];
  logic signed [NW-1:0] n_q [3];
  logic signed [EW-1:0] ax_e [9][3];
  logic [9:0]           sep_cell;
  logic                 ovl_d, ovl_q;
  cell_en_t             cell_en;

  // Box registers; the user must write them only while the block is idle, the block itself does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        box_lo_q[k] <= '0;
        box_hi_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOX_LO_X: box_lo_q[0] <= cfg_data_i;
        REG_BOX_LO_Y: box_lo_q[1] <= cfg_data_i;
        REG_BOX_LO_Z: box_lo_q[2] <= cfg_data_i;
        REG_BOX_HI_X: box_hi_q[0] <= cfg_data_i;
        REG_BOX_HI_Y: box_hi_q[1] <= cfg_data_i;
        REG_BOX_HI_Z: box_hi_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage loads when it is empty or its successor moves.
  always_comb begin
    rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_axis_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
    vld_d[0] = rdy[0] ? s_axis_tvalid : vld_q[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      vld_d[i] = rdy[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = rdy[0];

  // Unpack vertices, box axis test, edge vectors.
  always_comb begin
    sepbox_d = 1'b0;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        in_v[j][k] = s_axis_tdata[(j*3+k)*W +: W];
      end
    end
    for (int k = 0; k < 3; k++) begin
      vmn[k] = in_v[0][k];
      vmx[k] = in_v[0][k];
      for (int j = 1; j < 3; j++) begin
        if (in_v[j][k] < vmn[k]) vmn[k] = in_v[j][k];
        if (in_v[j][k] > vmx[k]) vmx[k] = in_v[j][k];
      end
      if ((vmx[k] < box_lo_q[k]) || (vmn[k] > box_hi_q[k])) sepbox_d = 1'b1;
      eu_d[k]      = EW'(in_v[1][k]) - EW'(in_v[0][k]);
      ev_d[k]      = EW'(in_v[2][k]) - EW'(in_v[0][k]);
      edge_d[0][k] = EW'(in_v[0][k]) - EW'(in_v[1][k]);
      edge_d[1][k] = EW'(in_v[0][k]) - EW'(in_v[2][k]);
      edge_d[2][k] = EW'(in_v[1][k]) - EW'(in_v[2][k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      eu_q    <= eu_d;
      ev_q    <= ev_d;
      edge1_q <= edge_d;
      vert1_q <= in_v;
      sb_q[0] <= sepbox_d;
    end
  end

  // Normal products.
  always_comb begin
    np_d[0] = PW'(eu_q[1]) * PW'(ev_q[2]);
    np_d[1] = PW'(eu_q[2]) * PW'(ev_q[1]);
    np_d[2] = PW'(eu_q[2]) * PW'(ev_q[0]);
    np_d[3] = PW'(eu_q[0]) * PW'(ev_q[2]);
    np_d[4] = PW'(eu_q[0]) * PW'(ev_q[1]);
    np_d[5] = PW'(eu_q[1]) * PW'(ev_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      np_q    <= np_d;
      edge2_q <= edge1_q;
      vert2_q <= vert1_q;
      sb_q[1] <= sb_q[0];
    end
  end

  // Normal components.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_d[k] = NW'(np_q[2*k]) - NW'(np_q[2*k+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      n_q     <= n_d;
      edge3_q <= edge2_q;
      vert3_q <= vert2_q;
      sb_q[2] <= sb_q[1];
    end
  end

  // Box axis result follows the cell stages.
  always_ff @(posedge clk_i) begin
    if (rdy[3]) sb_q[3] <= sb_q[2];
    if (rdy[4]) sb_q[4] <= sb_q[3];
    if (rdy[5]) sb_q[5] <= sb_q[4];
    if (rdy[6]) sb_q[6] <= sb_q[5];
  end

  assign cell_en = '{c1: rdy[3], c2: rdy[4], c3: rdy[5], c4: rdy[6]};

  // Edge cross box axis vectors.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax_e[i*3+0][0] = '0;
      ax_e[i*3+0][1] = edge3_q[i][2];
      ax_e[i*3+0][2] = EW'(-edge3_q[i][1]);
      ax_e[i*3+1][0] = EW'(-edge3_q[i][2]);
      ax_e[i*3+1][1] = '0;
      ax_e[i*3+1][2] = edge3_q[i][0];
      ax_e[i*3+2][0] = edge3_q[i][1];
      ax_e[i*3+2][1] = EW'(-edge3_q[i][0]);
      ax_e[i*3+2][2] = '0;
    end
  end

  for (genvar g = 0; g < 9; g++) begin : g_edge_cell
    tbo_axis_cell #(
      .COORD_BITS (W),
      .AXIS_BITS  (EW)
    ) u_cell (
      .clk_i    (clk_i),
      .en_i     (cell_en),
      .axis_i   (ax_e[g]),
      .box_lo_i (box_lo_q),
      .box_hi_i (box_hi_q),
      .vert_i   (vert3_q),
      .sep_o    (sep_cell[g])
    );
  end

  // Plane cell: every vertex projects to the same value on the normal.
  tbo_axis_cell #(
    .COORD_BITS (W),
    .AXIS_BITS  (NW)
  ) u_plane_cell (
    .clk_i    (clk_i),
    .en_i     (cell_en),
    .axis_i   (n_q),
    .box_lo_i (box_lo_q),
    .box_hi_i (box_hi_q),
    .vert_i   (vert3_q),
    .sep_o    (sep_cell[9])
  );

  // Output register.
  assign ovl_d = !(sb_q[6] || (|sep_cell));

  always_ff @(posedge clk_i) begin
    if (rdy[NUM_STAGES-1]) begin
      ovl_q <= ovl_d;
    end
  end

  assign m_axis_tvalid = vld_q[NUM_STAGES-1];
  assign m_axis_tdata  = {7'b0000000, ovl_q};

endmodule

`default_nettype wire

@@ sv/tbo_checker.sv @@
`default_nettype none

module tbo_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // No result is shown while reset is applied.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // With the output stage empty, the whole pipeline can take a request.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Nothing can have reached the output in the cycle after reset release.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("result right after reset");

endmodule

bind triangle_box_overlap_test_core tbo_checker u_tbo_checker (.*);

`default_nettype wire

@@ tb/triangle_box_overlap_test_core_test.sv @@
`default_nettype none

module triangle_box_overlap_test_core_test;
  import tbo_pkg::*;

  localparam int CB = 16;
  localparam int LATENCY_WAIT = 20;
  // Indexes past the last box register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef logic signed [CB-1:0] trig_t [9];

  // Queue of expected overlap flags plus mismatch bookkeeping.
  class overlap_scoreboard;
    bit flags_q[$];
    int mismatches;
    int checked;
    int hits;

    function void note(bit flag);
      flags_q = {flags_q, flag};
    endfunction

    function void check(bit got);
      bit want;
      if (flags_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: got %0d, nothing pending", got);
      end else begin
        want = flags_q.pop_front();
        checked++;
        if (got) hits++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("overlap mismatch #%0d: expected %0d actual %0d", checked, want, got);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CB-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [143:0] s_axis_tdata = '0; // a_x a_y a_z b_x b_y b_z c_x c_y c_z from bit 0
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // overlaps in bit 0

  overlap_scoreboard sb = new();
  logic signed [CB-1:0] box_m [6];
  bit burst_mode = 1'b0;
  bit hold_req = 1'b0;
  int sent = 0;

  triangle_box_overlap_test_core #(.COORD_BITS(CB)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Separating-axis prediction over the box copy held here.
  function automatic bit predict_overlap(trig_t t);
    longint v[3][3], lo[3], hi[3], n[3], e1[3], e2[3], ed[3][3], ax[3], p[3];
    longint mn, mx, s, bmn, bmx, tmn, tmx, q;
    bit neg, pos;
    neg = 0;
    pos = 0;
    for (int i = 0; i < 3; i++) begin
      lo[i] = box_m[i];
      hi[i] = box_m[3 + i];
      for (int k = 0; k < 3; k++) v[i][k] = t[i * 3 + k];
    end
    // Box axes.
    for (int k = 0; k < 3; k++) begin
      mn = v[0][k];
      mx = v[0][k];
      for (int i = 1; i < 3; i++) begin
        if (v[i][k] < mn) mn = v[i][k];
        if (v[i][k] > mx) mx = v[i][k];
      end
      if (mx < lo[k] || mn > hi[k]) return 1'b0;
    end
    // Triangle plane; the products stay well inside 64 bits at this width.
    for (int k = 0; k < 3; k++) begin
      e1[k] = v[1][k] - v[0][k];
      e2[k] = v[2][k] - v[0][k];
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    for (int c = 0; c < 8; c++) begin
      p[0] = c[0] ? hi[0] : lo[0];
      p[1] = c[1] ? hi[1] : lo[1];
      p[2] = c[2] ? hi[2] : lo[2];
      s = n[0] * (p[0] - v[0][0]) + n[1] * (p[1] - v[0][1]) + n[2] * (p[2] - v[0][2]);
      if (s <= 0) neg = 1;
      if (s >= 0) pos = 1;
    end
    if (!(neg && pos)) return 1'b0;
    // Edge cross box axis, strict comparisons.
    for (int k = 0; k < 3; k++) begin
      ed[0][k] = v[0][k] - v[1][k];
      ed[1][k] = v[0][k] - v[2][k];
      ed[2][k] = v[1][k] - v[2][k];
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (j == 0) begin
          ax[0] = 0; ax[1] = ed[i][2]; ax[2] = -ed[i][1];
        end else if (j == 1) begin
          ax[0] = -ed[i][2]; ax[1] = 0; ax[2] = ed[i][0];
        end else begin
          ax[0] = ed[i][1]; ax[1] = -ed[i][0]; ax[2] = 0;
        end
        for (int c = 0; c < 8; c++) begin
          q = ax[0] * (c[0] ? hi[0] : lo[0]) + ax[1] * (c[1] ? hi[1] : lo[1])
            + ax[2] * (c[2] ? hi[2] : lo[2]);
          if (c == 0 || q < bmn) bmn = q;
          if (c == 0 || q > bmx) bmx = q;
        end
        for (int c = 0; c < 3; c++) begin
          q = ax[0] * v[c][0] + ax[1] * v[c][1] + ax[2] * v[c][2];
          if (c == 0 || q < tmn) tmn = q;
          if (c == 0 || q > tmx) tmx = q;
        end
        if (bmx < tmn || bmn > tmx) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic int gap_draw();
    return burst_mode ? 0 : int'($urandom_range(0, 17));
  endfunction

  // Coordinate around the box on axis k, a little past either face.
  function automatic logic [CB-1:0] near_coord(int k);
    int a, b, s;
    a = (box_m[k] < box_m[k + 3]) ? box_m[k] : box_m[k + 3];
    b = (box_m[k] < box_m[k + 3]) ? box_m[k + 3] : box_m[k];
    s = $urandom_range(0, 600);
    return CB'(a - s + int'($urandom_range(0, b - a + 2 * s)));
  endfunction

  // One box register write; the copy here follows the block's rule.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CB-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx <= REG_BOX_HI_Z) box_m[idx] = val;
  endtask

  task automatic load_box(int lx, int ly, int lz, int hx, int hy, int hz);
    write_reg(REG_BOX_LO_X, CB'(lx));
    write_reg(REG_BOX_LO_Y, CB'(ly));
    write_reg(REG_BOX_LO_Z, CB'(lz));
    write_reg(REG_BOX_HI_X, CB'(hx));
    write_reg(REG_BOX_HI_Y, CB'(hy));
    write_reg(REG_BOX_HI_Z, CB'(hz));
    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CB'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one triangle and note its expected flag once it is taken.
  task automatic send_triangle(trig_t t);
    int n;
    n = gap_draw();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    for (int i = 0; i < 9; i++) s_axis_tdata[i * CB +: CB] <= t[i];
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sb.note(predict_overlap(t));
    sent++;
  endtask

  task automatic send_vertices(int ax, int ay, int az, int bx, int by, int bz,
                               int cx, int cy, int cz);
    trig_t t;
    t = '{CB'(ax), CB'(ay), CB'(az), CB'(bx), CB'(by), CB'(bz), CB'(cx), CB'(cy), CB'(cz)};
    send_triangle(t);
  endtask

  // Drop valid, then wait for every pending result and the pipe to drain.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.flags_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY_WAIT) @(posedge clk_i);
  endtask

  task automatic random_triangles(int count);
    trig_t t;
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
        if (mode < 2) t[i] = CB'($urandom);
        else t[i] = near_coord(i % 3);
      end
      // Occasionally collapse the triangle to a line or a point.
      if (mode == 9) for (int k = 0; k < 3; k++) t[6 + k] = t[3 + k];
      send_triangle(t);
    end
  endtask

  // Result side: random stalls, and one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (120) @(posedge clk_i);
      end
      n = gap_draw();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready) && !hold_req);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata[0]);
  end

  initial begin
    int lx, ly, lz;
    for (int i = 0; i < 6; i++) box_m[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: the reset box is the single point at the origin.
    send_vertices(-256, -256, 0, 256, -256, 0, 0, 256, 0);
    send_vertices(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_vertices(5, 5, 5, 5, 5, 5, 5, 5, 5);
    send_vertices(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_vertices(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_vertices(-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768);
    send_vertices(-32768, 32767, 0, 32767, -32768, 0, 0, 0, 32767);
    drain();

    // Directed against a box from -256 to 256 on each axis: touching faces, plane misses, lines.
    load_box(-256, -256, -256, 256, 256, 256);
    send_vertices(256, 0, 0, 600, 0, 0, 600, 100, 0);
    send_vertices(257, 0, 0, 600, 0, 0, 600, 100, 0);
    send_vertices(768, 0, 0, 0, 768, 0, 0, 0, 768);
    send_vertices(800, 0, 0, 0, 800, 0, 0, 0, 800);
    send_vertices(-800, 0, 0, 0, -800, 0, 0, 0, -800);
    send_vertices(-1000, -1000, 0, 1000, 1000, 0, 3000, 3000, 0);
    send_vertices(300, 300, -5000, 300, 300, 5000, -5000, -5000, 700);
    send_vertices(0, 600, -600, 0, -600, 600, 0, 600, 600);
    send_vertices(512, 0, -300, 0, 512, -300, 512, 0, 300);
    send_vertices(600, 0, 100, 0, 600, 100, 0, 600, -100);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_box(-32768, -32768, -32768, 32767, 32767, 32767);
        1: load_box(300, -200, 400, -300, 200, -400);
        2: load_box(32767, 32767, 32767, 32767, 32767, 32767);
        3: load_box(-32768, -32768, -32768, -32000, -32000, -32000);
        default: begin
          lx = int'($urandom_range(0, 60000)) - 32768;
          ly = int'($urandom_range(0, 60000)) - 32768;
          lz = int'($urandom_range(0, 60000)) - 32768;
          load_box(lx, ly, lz, lx + int'($urandom_range(0, 2000)),
                   ly + int'($urandom_range(0, 2000)), lz + int'($urandom_range(0, 2000)));
        end
      endcase
      burst_mode = (ph == 4 || ph == 6);
      if (ph == 4) hold_req = 1'b1;
      random_triangles(166);
      drain();
    end
    burst_mode = 1'b0;

    $display("sent %0d triangles over ten box settings, %0d results checked, %0d overlapping",
             sent, sb.checked, sb.hits);
    if (sb.mismatches == 0 && sb.flags_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.flags_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
sv/tbo_pkg.sv
sv/tbo_axis_cell.sv
sv/triangle_box_overlap_test_core.sv
sv/tbo_checker.sv
tb/triangle_box_overlap_test_core_test.sv
